// ===== sv/e2h_pkg.sv =====
// ============================================================================
// e2h_pkg: shared types, constants and functions of the coordinate transform
// Angle widths, CORDIC step count, pipeline latencies, the queue item
// format and the elaboration-time arctangent table builder.
// ============================================================================
package e2h_pkg;

    // Field width and CORDIC length
    localparam int ANGLE_BITS   = 32;
    localparam int CORDIC_STEPS = 28;
    localparam int TABLE_LEN    = 62;
    localparam int STEPS        = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    // Internal fixed point: 64-bit words, Q60 vectors, 2^64 per turn
    localparam int FRAC_BITS = 60;
    localparam logic signed [63:0] GAIN_Q60        = 64'sd700114967507363239;
    localparam logic [63:0]        TWO_OVER_PI_Q64 = 64'hA2F9836E4E441529;
    localparam logic signed [63:0] QUARTER_TURN    = 64'sh4000000000000000;
    localparam logic [63:0]        HALF_TURN       = 64'h8000000000000000;
    localparam logic [63:0]        ROUND_HALF      = 64'd1 << (63 - ANGLE_BITS);
    localparam logic signed [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    // Pipeline latencies in enabled cycles
    localparam int ROT_LAT = STEPS + 2;
    localparam int VEC_LAT = STEPS + 2;
    localparam int MUL_LAT = 4;
    localparam int PIPE_LEN = ROT_LAT + 2 * MUL_LAT + 1 + VEC_LAT + MUL_LAT + VEC_LAT;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int PDATA_W = (ANGLE_BITS > 32) ? 64 : 32;
    localparam int PADDR_W = (ANGLE_BITS > 32) ? 4 : 3;

    typedef enum logic {
        REG_LATITUDE  = 1'b0,
        REG_LONGITUDE = 1'b1
    } cfg_reg_t;

    // Classified item: hour angle, clamped declination and latitude, pole flag
    typedef struct packed {
        logic [ANGLE_BITS-1:0] hour_angle;
        logic [ANGLE_BITS-1:0] dec;
        logic [ANGLE_BITS-1:0] lat;
        logic                  pole;
    } item_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } queue_stat_t;

    // Restoring long division, elaboration use only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-idx) in 2^64 per turn, from the integer arctangent series
    function automatic logic [63:0] atan_entry(input int idx);
        logic [63:0]  acc;
        logic [63:0]  term;
        logic [127:0] prod;
        int           e;
        acc = '0;
        if (idx == 0) begin
            return 64'd1 << 61;
        end
        for (int k = 0; k < 32; k++) begin
            e = 62 - idx * (2 * k + 1);
            if (e >= 0) begin
                term = udiv64(64'd1 << e, 64'(2 * k + 1));
                if ((k & 1) != 0) acc = acc - term;
                else              acc = acc + term;
            end
        end
        prod = 128'(acc) * 128'(TWO_OVER_PI_Q64);
        return prod[127:64];
    endfunction

    // Field angle to internal turn
    function automatic logic [63:0] lift(input logic [ANGLE_BITS-1:0] v);
        return {v, {(64 - ANGLE_BITS){1'b0}}};
    endfunction

    // Internal turn to field angle, round half up
    function automatic logic [ANGLE_BITS-1:0] to_field(input logic [63:0] t);
        logic [63:0] s;
        s = t + ROUND_HALF;
        return s[63:64-ANGLE_BITS];
    endfunction

endpackage

// ===== sv/e2h_front.sv =====
// ============================================================================
// e2h_front: input classification
// Forms the hour angle, clamps declination and latitude to a quarter turn
// and flags stars at a celestial pole.
// ============================================================================
module e2h_front (
    input  logic [e2h_pkg::ANGLE_BITS-1:0] right_ascension_angle,
    input  logic [e2h_pkg::ANGLE_BITS-1:0] declination_angle,
    input  logic [e2h_pkg::ANGLE_BITS-1:0] sidereal_angle,
    input  logic [e2h_pkg::ANGLE_BITS-1:0] latitude,
    input  logic [e2h_pkg::ANGLE_BITS-1:0] longitude,
    output e2h_pkg::item_t                 item
);

    function automatic logic [e2h_pkg::ANGLE_BITS-1:0] clamp_quarter(
        input logic [e2h_pkg::ANGLE_BITS-1:0] v
    );
        if ($signed(v) > e2h_pkg::QUARTER) begin
            return e2h_pkg::QUARTER;
        end
        if ($signed(v) < -e2h_pkg::QUARTER) begin
            return -e2h_pkg::QUARTER;
        end
        return v;
    endfunction

    logic [e2h_pkg::ANGLE_BITS-1:0] dec_c;

    // hour angle wraps modulo one turn
    always_comb
    begin
        dec_c           = clamp_quarter(declination_angle);
        item.hour_angle = sidereal_angle + longitude - right_ascension_angle;
        item.dec        = dec_c;
        item.lat        = clamp_quarter(latitude);
        item.pole       = (dec_c == e2h_pkg::QUARTER) || (dec_c == -e2h_pkg::QUARTER);
    end

endmodule

// ===== sv/e2h_queue.sv =====
// ============================================================================
// e2h_queue: short FIFO between front and back
// Register-based, one write and one read per cycle.
// ============================================================================
module e2h_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  e2h_pkg::item_t        push_item,
    input  logic                  pop,
    output e2h_pkg::item_t        head,
    output e2h_pkg::queue_stat_t  stat
);

    e2h_pkg::item_t                entry_reg [e2h_pkg::QUEUE_DEPTH];
    logic [e2h_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [e2h_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [e2h_pkg::QCNT_W-1:0]    count_reg, count_next;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == e2h_pkg::QPTR_W'(e2h_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == e2h_pkg::QPTR_W'(e2h_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == e2h_pkg::QCNT_W'(e2h_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

endmodule

// ===== sv/e2h_qmul.sv =====
// ============================================================================
// e2h_qmul: pipelined Q60 x Q60 multiplier
// Sign-magnitude, four 32x32 partial products, truncation toward zero.
// Four stages.
// ============================================================================
module e2h_qmul (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] p
);

    logic         sign1_reg, sign2_reg, sign3_reg;
    logic [63:0]  ua_reg, ub_reg;
    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [63:0]  mag_reg;
    logic [63:0]  p_reg;
    logic [127:0] sum;

    // partial product sum, bits of Q60 result
    assign sum = {64'd0, p00_reg}
               + {32'd0, p01_reg, 32'd0}
               + {32'd0, p10_reg, 32'd0}
               + {p11_reg, 64'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: magnitudes
            sign1_reg <= a[63] ^ b[63];
            ua_reg    <= a[63] ? 64'(-a) : 64'(a);
            ub_reg    <= b[63] ? 64'(-b) : 64'(b);
            // stage 2: partial products
            sign2_reg <= sign1_reg;
            p00_reg   <= ua_reg[31:0]  * ub_reg[31:0];
            p01_reg   <= ua_reg[31:0]  * ub_reg[63:32];
            p10_reg   <= ua_reg[63:32] * ub_reg[31:0];
            p11_reg   <= ua_reg[63:32] * ub_reg[63:32];
            // stage 3: sum and scale
            sign3_reg <= sign2_reg;
            mag_reg   <= sum[e2h_pkg::FRAC_BITS+63:e2h_pkg::FRAC_BITS];
            // stage 4: sign
            p_reg     <= sign3_reg ? -mag_reg : mag_reg;
        end
    end

    assign p = $signed(p_reg);

endmodule

// ===== sv/e2h_rotate.sv =====
// ============================================================================
// e2h_rotate: pipelined rotation CORDIC, sine and cosine of a turn angle
// Folds into a quarter turn, one stage per step, then restores the sign.
// ============================================================================
module e2h_rotate (
    input  logic               clk,
    input  logic               en,
    input  logic [63:0]        angle,
    output logic signed [63:0] sin_out,
    output logic signed [63:0] cos_out
);

    logic signed [63:0] x_reg  [e2h_pkg::STEPS+1];
    logic signed [63:0] y_reg  [e2h_pkg::STEPS+1];
    logic signed [63:0] th_reg [e2h_pkg::STEPS+1];
    logic               neg_reg [e2h_pkg::STEPS+1];
    logic signed [63:0] sin_reg, cos_reg;
    logic signed [63:0] th_in;
    logic               fold;

    // half-turn fold when beyond a quarter turn
    always_comb
    begin
        th_in = $signed(angle);
        fold  = (th_in > e2h_pkg::QUARTER_TURN) || (th_in < -e2h_pkg::QUARTER_TURN);
        if (fold)
        begin
            th_in = $signed({~angle[63], angle[62:0]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= e2h_pkg::GAIN_Q60;
            y_reg[0]   <= '0;
            th_reg[0]  <= th_in;
            neg_reg[0] <= fold;
        end
    end

    // CORDIC steps
    for (genvar i = 0; i < e2h_pkg::STEPS; i++)
    begin : g_step
        localparam logic signed [63:0] ATAN = $signed(e2h_pkg::atan_entry(i));
        logic signed [63:0] dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!th_reg[i][63])
                begin
                    x_reg[i+1]  <= x_reg[i] - dx;
                    y_reg[i+1]  <= y_reg[i] + dy;
                    th_reg[i+1] <= th_reg[i] - ATAN;
                end
                else
                begin
                    x_reg[i+1]  <= x_reg[i] + dx;
                    y_reg[i+1]  <= y_reg[i] - dy;
                    th_reg[i+1] <= th_reg[i] + ATAN;
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    // undo the fold
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= neg_reg[e2h_pkg::STEPS] ? -y_reg[e2h_pkg::STEPS] : y_reg[e2h_pkg::STEPS];
            cos_reg <= neg_reg[e2h_pkg::STEPS] ? -x_reg[e2h_pkg::STEPS] : x_reg[e2h_pkg::STEPS];
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

// ===== sv/e2h_vector.sv =====
// ============================================================================
// e2h_vector: pipelined vectoring CORDIC, atan2 and magnitude
// Left half-plane mapped by negation plus a half turn; zero vector gives 0.
// ============================================================================
module e2h_vector (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] x_in,
    input  logic signed [63:0] y_in,
    output logic signed [63:0] mag,
    output logic [63:0]        angle
);

    logic signed [63:0] x_reg [e2h_pkg::STEPS+1];
    logic signed [63:0] y_reg [e2h_pkg::STEPS+1];
    logic signed [63:0] z_reg [e2h_pkg::STEPS+1];
    logic [63:0]        base_reg [e2h_pkg::STEPS+1];
    logic               zero_reg [e2h_pkg::STEPS+1];
    logic signed [63:0] mag_reg;
    logic [63:0]        angle_reg;

    // pre-rotation into the right half-plane
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            x_reg[0]    <= x_in[63] ? -x_in : x_in;
            y_reg[0]    <= x_in[63] ? -y_in : y_in;
            base_reg[0] <= x_in[63] ? e2h_pkg::HALF_TURN : '0;
            z_reg[0]    <= '0;
        end
    end

    // CORDIC steps
    for (genvar i = 0; i < e2h_pkg::STEPS; i++)
    begin : g_step
        localparam logic signed [63:0] ATAN = $signed(e2h_pkg::atan_entry(i));
        logic signed [63:0] dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_reg[i][63])
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
                base_reg[i+1] <= base_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // result, forced to zero for a zero vector
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= zero_reg[e2h_pkg::STEPS] ? '0 : x_reg[e2h_pkg::STEPS];
            angle_reg <= zero_reg[e2h_pkg::STEPS] ? '0
                         : base_reg[e2h_pkg::STEPS] + 64'(z_reg[e2h_pkg::STEPS]);
        end
    end

    assign mag   = mag_reg;
    assign angle = angle_reg;

endmodule

// ===== sv/e2h_back.sv =====
// ============================================================================
// e2h_back: transform datapath
// Three sine/cosine units, two product rounds, azimuth and altitude
// vectoring passes with a gain multiplier between them, and the output
// register. Advances whenever the output register is free or being taken.
// ============================================================================
module e2h_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  e2h_pkg::item_t                 head,
    input  logic                           head_valid,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [e2h_pkg::ANGLE_BITS-1:0] altitude_angle,
    output logic [e2h_pkg::ANGLE_BITS-1:0] azimuth_angle
);

    localparam int ML = e2h_pkg::MUL_LAT;
    localparam int VL = e2h_pkg::VEC_LAT;
    localparam int PL = e2h_pkg::PIPE_LEN;

    logic en;
    logic               vld_reg  [PL];
    logic               pole_reg [PL];
    logic               out_valid_reg;
    logic [e2h_pkg::ANGLE_BITS-1:0] alt_reg, az_reg;

    logic signed [63:0] sl, cl, sd, cd, shh, chh;
    logic signed [63:0] cdch, a_p, slsd, sdcl, t1, t2;
    logic signed [63:0] sl_d [ML];
    logic signed [63:0] cl_d [ML];
    logic signed [63:0] a_d [ML];
    logic signed [63:0] slsd_d [ML];
    logic signed [63:0] sdcl_d [ML];
    logic signed [63:0] b_reg, z_reg, a_reg;
    logic signed [63:0] z_d [VL+ML];
    logic [63:0]        az_d [ML+VL];
    logic signed [63:0] mag1, kmag, mag2;
    logic [63:0]        az1, alt_ang;
    logic signed [63:0] alt_c;

    assign en  = !out_valid_reg || out_ready;
    assign pop = en && head_valid;

    // sine and cosine of latitude, declination and hour angle
    e2h_rotate u_rot_lat (.clk(clk), .en(en), .angle(e2h_pkg::lift(head.lat)),
                          .sin_out(sl), .cos_out(cl));
    e2h_rotate u_rot_dec (.clk(clk), .en(en), .angle(e2h_pkg::lift(head.dec)),
                          .sin_out(sd), .cos_out(cd));
    e2h_rotate u_rot_ha  (.clk(clk), .en(en), .angle(e2h_pkg::lift(head.hour_angle)),
                          .sin_out(shh), .cos_out(chh));

    // first product round
    e2h_qmul u_mul_cdch (.clk(clk), .en(en), .a(cd), .b(chh), .p(cdch));
    e2h_qmul u_mul_a    (.clk(clk), .en(en), .a(cd), .b(shh), .p(a_p));
    e2h_qmul u_mul_slsd (.clk(clk), .en(en), .a(sl), .b(sd),  .p(slsd));
    e2h_qmul u_mul_sdcl (.clk(clk), .en(en), .a(sd), .b(cl),  .p(sdcl));

    // second product round
    e2h_qmul u_mul_t1 (.clk(clk), .en(en), .a(sl_d[ML-1]), .b(cdch), .p(t1));
    e2h_qmul u_mul_t2 (.clk(clk), .en(en), .a(cl_d[ML-1]), .b(cdch), .p(t2));

    // azimuth pass, gain compensation, altitude pass
    e2h_vector u_vec_az (.clk(clk), .en(en), .x_in(b_reg), .y_in(a_reg),
                         .mag(mag1), .angle(az1));
    e2h_qmul   u_mul_k  (.clk(clk), .en(en), .a(mag1), .b(e2h_pkg::GAIN_Q60), .p(kmag));
    e2h_vector u_vec_alt (.clk(clk), .en(en), .x_in(kmag), .y_in(z_d[VL+ML-1]),
                          .mag(mag2), .angle(alt_ang));

    // delay lines and the b/z combine stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sl_d[0]   <= sl;
            cl_d[0]   <= cl;
            a_d[0]    <= a_p;
            slsd_d[0] <= slsd;
            sdcl_d[0] <= sdcl;
            for (int k = 1; k < ML; k++)
            begin
                sl_d[k]   <= sl_d[k-1];
                cl_d[k]   <= cl_d[k-1];
                a_d[k]    <= a_d[k-1];
                slsd_d[k] <= slsd_d[k-1];
                sdcl_d[k] <= sdcl_d[k-1];
            end
            b_reg <= t1 - sdcl_d[ML-1];
            z_reg <= slsd_d[ML-1] + t2;
            a_reg <= a_d[ML-1];
            z_d[0] <= z_reg;
            for (int k = 1; k < VL + ML; k++)
            begin
                z_d[k] <= z_d[k-1];
            end
            az_d[0] <= az1;
            for (int k = 1; k < ML + VL; k++)
            begin
                az_d[k] <= az_d[k-1];
            end
            pole_reg[0] <= head.pole;
            for (int k = 1; k < PL; k++)
            begin
                pole_reg[k] <= pole_reg[k-1];
            end
        end
    end

    // occupancy of the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PL; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= head_valid;
            for (int k = 1; k < PL; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            out_valid_reg <= vld_reg[PL-1];
        end
    end

    // altitude clamp to a quarter turn
    always_comb
    begin
        alt_c = $signed(alt_ang);
        if (alt_c > e2h_pkg::QUARTER_TURN)
        begin
            alt_c = e2h_pkg::QUARTER_TURN;
        end
        else if (alt_c < -e2h_pkg::QUARTER_TURN)
        begin
            alt_c = -e2h_pkg::QUARTER_TURN;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alt_reg <= e2h_pkg::to_field(64'(alt_c));
            az_reg  <= pole_reg[PL-1] ? '0 : e2h_pkg::to_field(az_d[ML+VL-1]);
        end
    end

    assign out_valid      = out_valid_reg;
    assign altitude_angle = alt_reg;
    assign azimuth_angle  = az_reg;

endmodule

// ===== sv/equatorial_to_horizontal.sv =====
// ============================================================================
// equatorial_to_horizontal: star position to altitude and azimuth
// Observer latitude and longitude in APB registers; pipelined CORDIC
// datapath, one star per cycle while the receiver does not stall.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries right ascension, declination
//   and sidereal angle; the output channel (out_valid/out_ready) returns
//   altitude and azimuth from south, one result per input transfer, in order.
//   Register 0 at address 0 is latitude, register 1 at address 4 longitude;
//   write them while the block is idle.
//   Throughput: one transfer per cycle while the receiver does not stall.
//   From input transfer to out_valid a star passes the queue, the three
//   CORDIC pipelines in series (sine/cosine, azimuth, altitude), three
//   four-stage multiplier rounds, the b/z combine stage and the output
//   register.
//   A four-entry queue splits the input classifier from the datapath.
//   When the receiver stalls, the whole datapath holds; the queue keeps
//   taking items until it is full, then in_ready drops.
//   Reset clears the registers to zero and empties queue and pipeline.
// ============================================================================
module equatorial_to_horizontal (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [e2h_pkg::PADDR_W-1:0]         paddr,
    input  logic [e2h_pkg::PDATA_W-1:0]         pwdata,
    output logic [e2h_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [e2h_pkg::ANGLE_BITS-1:0]      right_ascension_angle,
    input  logic signed [e2h_pkg::ANGLE_BITS-1:0] declination_angle,
    input  logic [e2h_pkg::ANGLE_BITS-1:0]      sidereal_angle,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [e2h_pkg::ANGLE_BITS-1:0] altitude_angle,
    output logic signed [e2h_pkg::ANGLE_BITS-1:0] azimuth_angle
);

    logic [e2h_pkg::ANGLE_BITS-1:0] lat_reg, lon_reg;
    e2h_pkg::cfg_reg_t              sel;
    e2h_pkg::item_t                 cls_item, head;
    e2h_pkg::queue_stat_t           q_stat;
    logic                           push, pop;
    logic [e2h_pkg::ANGLE_BITS-1:0] alt_u, az_u;

    // configuration registers
    assign pready = 1'b1;
    assign sel    = e2h_pkg::cfg_reg_t'(paddr[e2h_pkg::PADDR_W-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_reg <= '0;
            lon_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (sel)
                e2h_pkg::REG_LATITUDE:  lat_reg <= pwdata[e2h_pkg::ANGLE_BITS-1:0];
                e2h_pkg::REG_LONGITUDE: lon_reg <= pwdata[e2h_pkg::ANGLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            e2h_pkg::REG_LATITUDE:  prdata = e2h_pkg::PDATA_W'(lat_reg);
            e2h_pkg::REG_LONGITUDE: prdata = e2h_pkg::PDATA_W'(lon_reg);
            default:                prdata = '0;
        endcase
    end

    // front: classify
    e2h_front u_front (
        .right_ascension_angle(right_ascension_angle),
        .declination_angle    (declination_angle),
        .sidereal_angle       (sidereal_angle),
        .latitude             (lat_reg),
        .longitude            (lon_reg),
        .item                 (cls_item)
    );

    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;

    e2h_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_item(cls_item),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    // back: datapath
    e2h_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (!q_stat.empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .altitude_angle(alt_u),
        .azimuth_angle (az_u)
    );

    assign altitude_angle = $signed(alt_u);
    assign azimuth_angle  = $signed(az_u);

    // checks
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_stat.full)
        else $error("in_ready low while queue has room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= e2h_pkg::QCNT_W'(e2h_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_alt_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (altitude_angle <= e2h_pkg::QUARTER)
                   && (altitude_angle >= -e2h_pkg::QUARTER))
        else $error("altitude beyond a quarter turn");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for the equatorial to horizontal transform
// Drives stars over a valid/ready channel and observer registers over APB.
// A bit-exact CORDIC predictor builds the expected altitude and azimuth for
// every accepted star. Each result transfer is checked in order against it.
// ============================================================================
module tb_top;

    localparam int ANGLE_BITS = e2h_pkg::ANGLE_BITS;
    localparam int STEPS      = e2h_pkg::STEPS;
    localparam int TABLE_LEN  = e2h_pkg::TABLE_LEN;
    localparam int PADDR_W    = e2h_pkg::PADDR_W;
    localparam int PDATA_W    = e2h_pkg::PDATA_W;
    localparam logic signed [63:0] GAIN_Q60        = e2h_pkg::GAIN_Q60;
    localparam logic [63:0]        TWO_OVER_PI_Q64 = e2h_pkg::TWO_OVER_PI_Q64;
    localparam logic signed [63:0] QUARTER_TURN    = e2h_pkg::QUARTER_TURN;
    localparam logic [63:0]        HALF_TURN       = e2h_pkg::HALF_TURN;
    localparam logic signed [ANGLE_BITS-1:0] QUARTER = e2h_pkg::QUARTER;

    localparam int  DRAIN_CYCLES = 3 * STEPS + 60;
    localparam int  CYCLE_LIMIT  = 2000000;
    localparam longint HALF_SWAP = 64'h8000000000000000;

    typedef struct {
        logic [ANGLE_BITS-1:0] alt;
        logic [ANGLE_BITS-1:0] az;
    } horizon_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [ANGLE_BITS-1:0] right_ascension_angle = '0;
    logic signed [ANGLE_BITS-1:0] declination_angle = '0;
    logic [ANGLE_BITS-1:0] sidereal_angle = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [ANGLE_BITS-1:0] altitude_angle;
    logic signed [ANGLE_BITS-1:0] azimuth_angle;

    // Observer registers as the predictor sees them
    logic [ANGLE_BITS-1:0] obs_lat = '0;
    logic [ANGLE_BITS-1:0] obs_lon = '0;

    logic [63:0] atan_tab [TABLE_LEN];
    horizon_t    horizon_q[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          no_idle = 1'b0;
    bit          rx_hold = 1'b0;

    equatorial_to_horizontal i_dut (.*);

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void build_atan_table();
        logic [63:0]  acc;
        logic [63:0]  term;
        logic [127:0] prod;
        int           e;
        atan_tab[0] = 64'd1 << 61;
        for (int i = 1; i < TABLE_LEN; i++) begin
            acc = '0;
            for (int k = 0; 62 - i * (2 * k + 1) >= 0; k++) begin
                e = 62 - i * (2 * k + 1);
                term = (64'd1 << e) / 64'(2 * k + 1);
                if (k & 1) acc = acc - term;
                else       acc = acc + term;
            end
            prod = {64'b0, acc} * {64'b0, TWO_OVER_PI_Q64};
            atan_tab[i] = prod[127:64];
        end
    endfunction

    // Q60 product, truncated toward zero
    function automatic longint q60_mul(input longint a, input longint b);
        logic [63:0]  ua, ub, r;
        logic [127:0] p;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p  = {64'b0, ua} * {64'b0, ub};
        r  = p[123:60];
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    task automatic rotate_sincos(input logic [63:0] ang, output longint s, output longint c);
        longint th, x, y, dx, dy;
        bit     flip;
        th = longint'(ang);
        x = GAIN_Q60;
        y = 0;
        flip = 1'b0;
        // fold into +-quarter turn
        if (th > QUARTER_TURN || th < -QUARTER_TURN) begin
            th = th + HALF_SWAP;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (th >= 0) begin
                x -= dx; y += dy; th -= longint'(atan_tab[i]);
            end else begin
                x += dx; y -= dy; th += longint'(atan_tab[i]);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        s = y;
        c = x;
    endtask

    task automatic vector_angle(input longint xi, input longint yi,
                                output logic [63:0] ang, output longint mag);
        longint x, y, z, dx, dy;
        logic [63:0] base;
        x = xi; y = yi; z = 0; base = '0;
        if (x == 0 && y == 0) begin
            mag = 0;
            ang = '0;
        end else begin
            if (x < 0) begin
                x = -x; y = -y; base = HALF_TURN;
            end
            for (int i = 0; i < STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += longint'(atan_tab[i]);
                end else begin
                    x -= dx; y += dy; z -= longint'(atan_tab[i]);
                end
            end
            mag = x;
            ang = base + z;
        end
    endtask

    function automatic logic signed [ANGLE_BITS-1:0] clamp_quarter(
        input logic signed [ANGLE_BITS-1:0] v);
        if (v > QUARTER)  return QUARTER;
        if (v < -QUARTER) return -QUARTER;
        return v;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] round_turn(input logic [63:0] t);
        logic [63:0] s;
        s = t + (64'd1 << (63 - ANGLE_BITS));
        return s[63:64-ANGLE_BITS];
    endfunction

    task automatic star_to_horizon(input logic [ANGLE_BITS-1:0] ra,
                                   input logic [ANGLE_BITS-1:0] dec_in,
                                   input logic [ANGLE_BITS-1:0] st,
                                   output horizon_t h);
        logic signed [ANGLE_BITS-1:0] dec, lat;
        logic [ANGLE_BITS-1:0] ha;
        longint sl, cl, sd, cd, sh, ch, cdch, a, b, z, mag, alt;
        logic [63:0] az, alt_u;
        dec = clamp_quarter(dec_in);
        lat = clamp_quarter(obs_lat);
        ha  = st + obs_lon - ra;
        rotate_sincos({lat, {(64-ANGLE_BITS){1'b0}}}, sl, cl);
        rotate_sincos({dec, {(64-ANGLE_BITS){1'b0}}}, sd, cd);
        rotate_sincos({ha, {(64-ANGLE_BITS){1'b0}}}, sh, ch);
        cdch = q60_mul(cd, ch);
        a = q60_mul(cd, sh);
        b = q60_mul(sl, cdch) - q60_mul(sd, cl);
        z = q60_mul(sl, sd) + q60_mul(cl, cdch);
        vector_angle(b, a, az, mag);
        vector_angle(q60_mul(mag, GAIN_Q60), z, alt_u, mag);
        alt = longint'(alt_u);
        if (alt > QUARTER_TURN)  alt = QUARTER_TURN;
        if (alt < -QUARTER_TURN) alt = -QUARTER_TURN;
        h.alt = round_turn(alt);
        // star at a celestial pole: azimuth forced to zero
        h.az  = (dec == QUARTER || dec == -QUARTER) ? '0 : round_turn(az);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge clk) begin
        horizon_t e;
        if (rst_n && out_valid && out_ready) begin
            if (horizon_q.size() == 0) begin
                report("result transfer with nothing expected");
            end else begin
                e = horizon_q.pop_front();
                if (altitude_angle !== e.alt)
                    report($sformatf("altitude got %h want %h", altitude_angle, e.alt));
                if (azimuth_angle !== e.az)
                    report($sformatf("azimuth got %h want %h", azimuth_angle, e.az));
            end
        end
    end

    // Receiver: random stalls per transfer, plus a long hold on request
    initial begin
        int stall;
        forever begin
            @(negedge clk);
            stall = no_idle ? 0 : $urandom_range(0, 14);
            if (stall > 0 || rx_hold) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
                while (rx_hold) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_star(input logic [ANGLE_BITS-1:0] ra,
                             input logic [ANGLE_BITS-1:0] dec,
                             input logic [ANGLE_BITS-1:0] st);
        int gap;
        horizon_t h;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        right_ascension_angle <= ra;
        declination_angle     <= dec;
        sidereal_angle        <= st;
        in_valid              <= 1'b1;
        do @(posedge clk); while (!in_ready);
        star_to_horizon(ra, dec, st, h);
        horizon_q.push_back(h);
    endtask

    task automatic sender_idle();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Wait for every expected result, then let the pipeline settle
    task automatic drain();
        sender_idle();
        wait (horizon_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input e2h_pkg::cfg_reg_t idx, input logic [ANGLE_BITS-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= PDATA_W'(val);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == e2h_pkg::REG_LATITUDE) obs_lat = val;
        else                              obs_lon = val;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_observer(input logic [ANGLE_BITS-1:0] lat,
                                input logic [ANGLE_BITS-1:0] lon);
        drain();
        apb_write(e2h_pkg::REG_LATITUDE, lat);
        apb_write(e2h_pkg::REG_LONGITUDE, lon);
    endtask

    // Mostly in-range declinations, sometimes any pattern (saturation)
    function automatic logic [ANGLE_BITS-1:0] pick_dec();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return QUARTER;
            2:       return -QUARTER;
            default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        endcase
    endfunction

    task automatic run_sky(input int n);
        for (int i = 0; i < n; i++)
            send_star($urandom, pick_dec(), $urandom);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [ANGLE_BITS-1:0] decs[6];
        decs = '{32'h0, QUARTER, -QUARTER, 32'h7FFF_FFFF, 32'h8000_0000, 32'h2000_0000};
        // field extremes at the reset observer (equator, prime meridian)
        foreach (decs[i]) send_star(32'h0, decs[i], 32'h0);
        send_star(32'hFFFF_FFFF, 32'h0, 32'h0);
        send_star(32'h0, 32'h0, 32'hFFFF_FFFF);
        send_star(32'h8000_0000, 32'h1000_0000, 32'h0);
        send_star(32'h4000_0000, -32'sh1000_0000, 32'hC000_0000);
        // observer at the north pole; overshooting latitude after that
        set_observer(QUARTER, 32'h8000_0000);
        send_star(32'h0, QUARTER, 32'h0);
        send_star(32'h1234_5678, 32'h0, 32'h8765_4321);
        send_star(32'hFFFF_FFFF, -QUARTER, 32'hFFFF_FFFF);
        set_observer(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_star(32'h0, QUARTER, 32'h0);
        send_star(32'h0, 32'h0, 32'h0);
        set_observer(32'h8000_0000, 32'h0);
        send_star(32'h0, -QUARTER, 32'h0);
        send_star(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
        set_observer(-QUARTER, 32'hFFFF_FFFF);
        send_star(32'h0, -QUARTER, 32'h0);
        send_star(32'h0, QUARTER, 32'h0);
        send_star(32'h5555_5555, 32'h3FFF_FFFF, 32'hAAAA_AAAA);
    endtask

    task automatic test_observer_sweep();
        set_observer(QUARTER, 32'h8000_0000);
        run_sky(250);
        set_observer(-QUARTER, 32'h7FFF_FFFF);
        run_sky(250);
        for (int p = 0; p < 3; p++) begin
            set_observer($urandom_range(0, 32'h8000_0000) - 32'h4000_0000, $urandom);
            run_sky(250);
        end
        set_observer($urandom, $urandom);
        run_sky(100);
    endtask

    task automatic test_no_idle();
        set_observer(32'h1555_5555, 32'hF000_0000);
        no_idle = 1'b1;
        run_sky(200);
        no_idle = 1'b0;
    endtask

    // Receiver holds off while the sender keeps going, filling the block
    task automatic test_backpressure();
        set_observer($urandom_range(0, 32'h8000_0000) - 32'h4000_0000, $urandom);
        fork
            begin
                rx_hold = 1'b1;
                repeat (400) @(posedge clk);
                rx_hold = 1'b0;
            end
        join_none
        no_idle = 1'b1;
        run_sky(150);
        no_idle = 1'b0;
    endtask

    // Sender pauses until everything is back, then resumes
    task automatic test_pause();
        run_sky(40);
        drain();
        run_sky(40);
    endtask

    initial begin
        build_atan_table();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_observer_sweep();
        test_no_idle();
        test_backpressure();
        test_pause();
        drain();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== equatorial_to_horizontal.f =====
sv/e2h_pkg.sv
sv/e2h_front.sv
sv/e2h_queue.sv
sv/e2h_qmul.sv
sv/e2h_rotate.sv
sv/e2h_vector.sv
sv/e2h_back.sv
sv/equatorial_to_horizontal.sv
bench/tb_top.sv
